>>> sv/shuffled_base64_group_codec_defines.svh
// Assertion macros shared by the shuffled base64 group codec modules.
`ifndef SHUFFLED_BASE64_GROUP_CODEC_DEFINES_SVH
`define SHUFFLED_BASE64_GROUP_CODEC_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SBGC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SBGC_ASSERT(lbl, prop, msg)
`define SBGC_NEVER(lbl, expr, msg)
`endif
`endif

>>> sv/sbgc_pkg.sv
// Types, status codes and alphabet tables of the shuffled base64 group codec.
package sbgc_pkg;

  localparam int unsigned NumLanes = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CAP_SMALL = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_LTR   = 3'd3;
  localparam logic [2:0] ST_BAD_THIRD = 3'd4;
  localparam logic [2:0] ST_ABORTED   = 3'd5;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_LETTER = "Q";

  localparam logic [7:0] ALPHABET [0:63] = '{
    "z", "A", "R", "i", "j", "0", "B", "S", "1", "C", "k", "T", "U", "D", "2", "l",
    "3", "m", "E", "V", "n", "F", "4", "W", "X", "5", "G", "o", "p", "H", "6", "Y",
    "7", "q", "Z", "I", "r", "J", "8", "a", "s", "K", "9", "b", "c", "t", "-", "L",
    "_", "M", "d", "u", "e", "v", "N", "w", "O", "f", "g", "x", "P", "=", "y", "h"
  };

  typedef struct packed {
    logic        first_group;
    logic        last_group;
    logic [15:0] capacity;
    logic [1:0]  byte_count;
    logic [7:0]  in0;
    logic [7:0]  in1;
    logic [7:0]  in2;
    logic [7:0]  in3;
  } sbgc_in_t;

  typedef struct packed {
    logic [7:0]  out0;
    logic [7:0]  out1;
    logic [7:0]  out2;
    logic [7:0]  out3;
    logic [2:0]  out_count;
    logic [2:0]  status;
    logic [15:0] written_total;
    logic        message_done;
  } sbgc_out_t;

  // What one lane finds for its element, in both directions at once.
  typedef struct packed {
    logic [7:0] letter;
    logic [5:0] code;
    logic       code_ok;
  } sbgc_lane_t;

  function automatic logic [7:0] enc_letter(input logic [5:0] code);
    return ALPHABET[code];
  endfunction

  // Inverse lookup: 64 independent compares, one hit at most.
  function automatic logic [6:0] dec_letter(input logic [7:0] letter);
    logic [6:0] res;
    res = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[i] == letter) begin
        res = {1'b1, 6'(i)};
      end
    end
    return res;
  endfunction

endpackage

>>> sv/shuffled_base64_group_codec.sv
// Top level of the shuffled base64 group codec: four lanes, merging stage and output skid.
// This block encodes groups of one to three bytes into four letters of a shuffled
// URL-safe base64 alphabet with '=' in place of 'Q' (LSB-first packing, pad letter 'Q'),
// or decodes four letters back into one to three bytes, as the direction register selects.
// Every accepted item gives exactly one result item carrying the letters or bytes, their
// count, a status code, the bytes written so far in the message and an echo of last_group.
// A first group loads the message's output capacity; an error aborts the rest of the
// message until the next first group. The block takes one item per clock cycle while the
// skid stage is empty, and its result is registered: four lanes look up the four elements
// of a group side by side, and the one dependency from item to item, the capacity and byte
// count update in the merging stage, is combinational ahead of that stage's registers. An
// output register backed by a one-item skid stage keeps the input open while a finished
// result waits downstream; in_stall_o rises only once the skid stage is occupied. The
// direction register is written through its own valid/ready channel, which is always
// ready, and should only be changed while the block is idle.
`include "shuffled_base64_group_codec_defines.svh"
module shuffled_base64_group_codec import sbgc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sbgc_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sbgc_out_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_direction_i
);

  logic              in_acc;
  logic              out_pop;
  logic [23:0]       enc_v;
  logic [3:0][7:0]   letters;
  sbgc_lane_t        lanes [NumLanes];
  sbgc_out_t         result;

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  sbgc_out_t         out_q;
  sbgc_out_t         skid_q;
  logic              out_load_res;
  logic              out_load_skid;
  logic              skid_load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_pop     = out_valid_q && !out_stall_i;

  // Bytes beyond byte_count are masked before slicing, so short groups encode zeros.
  assign enc_v = {(in_item_i.byte_count == 2'd3) ? in_item_i.in2 : 8'h00,
                  in_item_i.byte_count[1] ? in_item_i.in1 : 8'h00,
                  in_item_i.in0};
  assign letters = {in_item_i.in3, in_item_i.in2, in_item_i.in1, in_item_i.in0};

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    sbgc_lane u_lane (
      .code_i   (enc_v[6*k +: 6]),
      .letter_i (letters[k]),
      .res_o    (lanes[k])
    );
  end

  sbgc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_direction_i (cfg_direction_i),
    .acc_i           (in_acc),
    .item_i          (in_item_i),
    .lanes_i         (lanes),
    .result_o        (result)
  );

  // The output register refills from the skid stage first; a new result lands in
  // the skid stage only when the output register is full and held.
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_load_res  = 1'b0;
    out_load_skid = 1'b0;
    skid_load     = 1'b0;
    if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_load_skid = 1'b1;
        out_valid_d   = 1'b1;
        skid_valid_d  = 1'b0;
      end else begin
        out_load_res = in_acc;
        out_valid_d  = in_acc;
      end
    end else if (in_acc) begin
      skid_load    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_skid) begin
      out_q <= skid_q;
    end else if (out_load_res) begin
      out_q <= result;
    end
    if (skid_load) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SBGC_NEVER(a_skid_needs_out, skid_valid_q && !out_valid_q, "skid without output")
  `SBGC_ASSERT(a_held_skid, in_acc && out_valid_q && out_stall_i |=> skid_valid_q, "item lost")

endmodule

>>> sv/sbgc_lane.sv
// One codec lane: alphabet lookup of a 6-bit code and inverse lookup of a letter.
module sbgc_lane import sbgc_pkg::*; (
  input  logic [5:0] code_i,
  input  logic [7:0] letter_i,
  output sbgc_lane_t res_o
);

  logic [6:0] dec;

  assign dec            = dec_letter(letter_i);
  assign res_o.letter   = enc_letter(code_i);
  assign res_o.code     = dec[5:0];
  assign res_o.code_ok  = dec[6];

endmodule

>>> sv/sbgc_merge.sv
// Merging stage: combines the lane results, checks capacity and keeps message state.
`include "shuffled_base64_group_codec_defines.svh"
module sbgc_merge import sbgc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_direction_i,
  input  logic       acc_i,
  input  sbgc_in_t   item_i,
  input  sbgc_lane_t lanes_i [NumLanes],
  output sbgc_out_t  result_o
);

  logic        direction_q;
  logic [15:0] space_q, space_d;
  logic [15:0] written_q, written_d;
  logic        aborted_q, aborted_d;

  logic [15:0] space_eff;
  logic [15:0] written_eff;
  logic        aborted_eff;
  logic [2:0]  status;
  logic [2:0]  need;
  logic [7:0]  o0, o1, o2, o3;
  logic [23:0] dec_v;
  logic [16:0] tally;

  assign dec_v = {lanes_i[3].code, lanes_i[2].code, lanes_i[1].code, lanes_i[0].code};

  always_comb begin
    space_eff   = item_i.first_group ? item_i.capacity : space_q;
    written_eff = item_i.first_group ? 16'd0 : written_q;
    aborted_eff = item_i.first_group ? 1'b0 : aborted_q;
    status      = ST_OK;
    need        = 3'd0;
    o0          = 8'h00;
    o1          = 8'h00;
    o2          = 8'h00;
    o3          = 8'h00;

    if (item_i.first_group && (direction_q == DIR_ENCODE) && (item_i.capacity < 16'd4)) begin
      status = ST_CAP_SMALL;
    end else if (aborted_eff) begin
      status = ST_ABORTED;
    end else if (direction_q == DIR_ENCODE) begin
      if (item_i.byte_count != 2'd0) begin
        if (space_eff < 16'd4) begin
          status = ST_FULL;
        end else begin
          o0   = lanes_i[0].letter;
          o1   = lanes_i[1].letter;
          o2   = item_i.byte_count[1] ? lanes_i[2].letter : PAD_LETTER;
          o3   = (item_i.byte_count == 2'd3) ? lanes_i[3].letter : PAD_LETTER;
          need = 3'd4;
        end
      end
    end else begin
      if (!lanes_i[0].code_ok || !lanes_i[1].code_ok) begin
        status = ST_BAD_LTR;
      end else if (lanes_i[3].code_ok && !lanes_i[2].code_ok) begin
        status = ST_BAD_THIRD;
      end else begin
        if (lanes_i[3].code_ok) begin
          need = 3'd3;
        end else if (lanes_i[2].code_ok) begin
          need = 3'd2;
        end else begin
          need = 3'd1;
        end
        if (space_eff < {13'd0, need}) begin
          status = ST_FULL;
          need   = 3'd0;
        end else begin
          o0 = dec_v[7:0];
          o1 = (need >= 3'd2) ? dec_v[15:8] : 8'h00;
          o2 = (need == 3'd3) ? dec_v[23:16] : 8'h00;
        end
      end
    end

    if (status != ST_OK) begin
      o0        = 8'h00;
      o1        = 8'h00;
      o2        = 8'h00;
      o3        = 8'h00;
      need      = 3'd0;
      aborted_d = (status != ST_ABORTED) ? 1'b1 : aborted_eff;
    end else begin
      aborted_d = aborted_eff;
    end
    space_d   = space_eff - {13'd0, need};
    written_d = written_eff + {13'd0, need};

    result_o.out0          = o0;
    result_o.out1          = o1;
    result_o.out2          = o2;
    result_o.out3          = o3;
    result_o.out_count     = need;
    result_o.status        = status;
    result_o.written_total = written_d;
    result_o.message_done  = item_i.last_group;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      direction_q <= cfg_direction_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q   <= 16'd0;
      written_q <= 16'd0;
      aborted_q <= 1'b0;
    end else if (acc_i) begin
      space_q   <= space_d;
      written_q <= written_d;
      aborted_q <= aborted_d;
    end
  end

  assign tally = {1'b0, space_q} + {1'b0, written_q};

  `SBGC_ASSERT(a_err_aborts, acc_i && (result_o.status != ST_OK) |=> aborted_q, "no abort")
  `SBGC_ASSERT(a_conserved, acc_i && !item_i.first_group |=> tally == $past(tally), "bytes lost")
  `SBGC_ASSERT(a_state_holds, !acc_i |=> $stable({space_q, written_q, aborted_q}), "state moved")

endmodule
